// ===== hw/rtl/lkv_pkg.sv =====
// Shared constants, codes and types for the LRU key/value cache.
`default_nettype none
package lkv_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_W       = 5;
   localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int DATA_W      = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_TOUCH  = 2'd1;
   localparam logic [1:0] CMD_INSERT = 2'd2;

   // recency table update, issued at most once per operation
   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] slot;
      logic [IDX_W-1:0] touch_rank;
      logic             evict;
   } rank_cmd_type;

   // key/value store write port
   typedef struct packed {
      logic              key_en;
      logic              val_en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
   } store_wr_type;

endpackage
`default_nettype wire

// ===== hw/rtl/lkv_req_if.sv =====
// Request channel: operation, key and value with valid/ready.
`default_nettype none
interface lkv_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic signed [31:0] lookup_key;
   logic signed [31:0] write_value;

   modport source (output valid, operation, lookup_key, write_value, input ready);
   modport sink   (input valid, operation, lookup_key, write_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lkv_rsp_if.sv =====
// Response channel: hit, read value and eviction report with valid/ready.
`default_nettype none
interface lkv_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic signed [31:0] read_value;
   logic        evicted;
   logic signed [31:0] evicted_key;

   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lkv_store.sv =====
// Key and value memories: one write port, one registered read port.
`default_nettype none
module lkv_store (
   input  wire logic                         clock,
   input  wire lkv_pkg::store_wr_type        wr,
   input  wire logic [lkv_pkg::IDX_W-1:0]    rd_addr,
   output logic      [lkv_pkg::DATA_W-1:0]   rd_key_ff,
   output logic      [lkv_pkg::DATA_W-1:0]   rd_val_ff
);

   logic [lkv_pkg::DATA_W-1:0] key_mem [lkv_pkg::MAX_ENTRIES];
   logic [lkv_pkg::DATA_W-1:0] val_mem [lkv_pkg::MAX_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr.key_en) begin
         key_mem[wr.addr] <= wr.key;
      end
      if (wr.val_en) begin
         val_mem[wr.addr] <= wr.value;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/lkv_recency.sv =====
// Valid bits, recency ranks and occupancy count with their update logic.
`default_nettype none
module lkv_recency (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               clear,
   input  wire lkv_pkg::rank_cmd_type              cmd,
   input  wire logic [lkv_pkg::IDX_W-1:0]          rd_idx,
   output logic      [lkv_pkg::IDX_W-1:0]          rd_rank,
   output logic      [lkv_pkg::MAX_ENTRIES-1:0]    valid_ff,
   output logic      [lkv_pkg::CNT_W-1:0]          count_ff
);

   logic [lkv_pkg::IDX_W-1:0]       rank_ff [lkv_pkg::MAX_ENTRIES];
   logic [lkv_pkg::IDX_W-1:0]       rank_in [lkv_pkg::MAX_ENTRIES];
   logic [lkv_pkg::MAX_ENTRIES-1:0] valid_in;
   logic [lkv_pkg::CNT_W-1:0]       count_in;

   assign rd_rank = rank_ff[rd_idx];

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      unique case (cmd.kind)
         lkv_pkg::CMD_TOUCH: begin
            // entries more recent than the touched one age by one
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
               if (valid_ff[i] && (lkv_pkg::IDX_W'(i) != cmd.slot) &&
                   (rank_ff[i] < cmd.touch_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[cmd.slot] = '0;
         end
         lkv_pkg::CMD_INSERT: begin
            // on eviction the target slot is the victim, so it is excluded here
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
               if (valid_ff[i] && (lkv_pkg::IDX_W'(i) != cmd.slot)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[cmd.slot]  = '0;
            valid_in[cmd.slot] = 1'b1;
            if (!cmd.evict) begin
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
         rank_ff[i] <= rank_in[i];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the LRU key/value cache: sequencer, shared key compare and response register.
//
// Fully associative key/value cache with least-recently-used replacement.
// Each request transfer is a get (operation 0) or a put (operation 1) and
// yields exactly one response transfer. A request is handled in turn by
// taking the transfer, a scan in which a single key comparator walks the
// key memory one slot per cycle through its registered read port, and a
// write-back of the recency ranks and the key/value memories.
// req_bus.ready is high only while no request is in progress and reset is
// low. The response sits in an output register, so a new request is taken
// while the previous response still waits; the write-back then holds until
// that response has been transferred. Keys compare as raw 32-bit patterns.
// A get miss returns -1, every put returns 0 in read_value. Writing
// csr_wr_data with csr_wr_en sets the capacity (0 acts as 1, above
// MAX_ENTRIES acts as MAX_ENTRIES) and empties the cache at once; write it
// only while no request is in progress. Reset empties the cache and sets
// the capacity to 16.
`default_nettype none
module lru_key_value_cache (
   input  wire logic                       clock,
   input  wire logic                       reset,
   lkv_req_if.sink                         req_bus,
   lkv_rsp_if.source                       rsp_bus,
   input  wire logic                       csr_wr_en,
   input  wire logic [lkv_pkg::CAP_W-1:0]  csr_wr_data
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;

   localparam int IW = lkv_pkg::IDX_W;
   localparam int DW = lkv_pkg::DATA_W;

   logic [1:0]                state_ff, state_in;
   logic [lkv_pkg::CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic                      cmp_live_ff, cmp_live_in;
   logic [IW-1:0]             cmp_idx_ff, cmp_idx_in;
   logic [lkv_pkg::CAP_W-1:0] cap_ff;

   // latched request
   logic          op_ff;
   logic [DW-1:0] key_ff, wval_ff;

   // scan results
   logic          hit_ff, vic_found_ff, free_found_ff;
   logic [IW-1:0] hit_slot_ff, touch_rank_ff, vic_slot_ff, vic_rank_ff, free_slot_ff;
   logic [DW-1:0] hit_val_ff, vic_key_ff;

   // response register
   logic          rsp_valid_ff;
   logic          rsp_hit_ff, rsp_evicted_ff;
   logic [DW-1:0] rsp_rd_ff, rsp_evk_ff;

   logic [DW-1:0]                   rd_key, rd_val;
   logic [IW-1:0]                   rd_rank;
   logic [lkv_pkg::MAX_ENTRIES-1:0] valid;
   logic [lkv_pkg::CNT_W-1:0]       count;
   lkv_pkg::rank_cmd_type           rank_cmd;
   lkv_pkg::store_wr_type           store_wr;

   logic                      req_xfer, rsp_xfer, advance, do_evict;
   logic                      slot_ok, key_match;
   logic [IW-1:0]             target;
   logic [lkv_pkg::CMP_W-1:0] eff_cap;

   assign req_xfer = req_bus.valid && req_bus.ready;
   assign rsp_xfer = rsp_valid_ff && rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && !reset;

   // write-back waits for the response register to be free
   assign advance = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = lkv_pkg::CMP_W'(1);
      end else if (lkv_pkg::CMP_W'(cap_ff) > lkv_pkg::CMP_W'(lkv_pkg::MAX_ENTRIES)) begin
         eff_cap = lkv_pkg::CMP_W'(lkv_pkg::MAX_ENTRIES);
      end else begin
         eff_cap = lkv_pkg::CMP_W'(cap_ff);
      end
   end

   assign do_evict = (op_ff == lkv_pkg::OP_PUT) && !hit_ff &&
                     (lkv_pkg::CMP_W'(count) >= eff_cap);
   assign target   = hit_ff ? hit_slot_ff : (do_evict ? vic_slot_ff : free_slot_ff);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      cmp_live_in = 1'b0;
      cmp_idx_in  = scan_cnt_ff[IW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in    = S_SCAN;
               scan_cnt_in = '0;
            end
         end
         S_SCAN: begin
            if (scan_cnt_ff < lkv_pkg::CNT_W'(lkv_pkg::MAX_ENTRIES)) begin
               cmp_live_in = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else begin
               // last compare happens this cycle
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (advance) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         scan_cnt_ff <= '0;
         cmp_live_ff <= 1'b0;
         cap_ff      <= lkv_pkg::CAP_RESET;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         cmp_live_ff <= cmp_live_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
   end

   // shared compare unit: one slot per cycle
   assign slot_ok   = valid[cmp_idx_ff];
   assign key_match = slot_ok && (rd_key == key_ff);

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff         <= req_bus.operation;
         key_ff        <= req_bus.lookup_key;
         wval_ff       <= req_bus.write_value;
         hit_ff        <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmp_live_ff) begin
         if (key_match) begin
            hit_ff        <= 1'b1;
            hit_slot_ff   <= cmp_idx_ff;
            touch_rank_ff <= rd_rank;
            hit_val_ff    <= rd_val;
         end
         // ties go to the later slot
         if (slot_ok && (!vic_found_ff || (rd_rank >= vic_rank_ff))) begin
            vic_found_ff <= 1'b1;
            vic_rank_ff  <= rd_rank;
            vic_slot_ff  <= cmp_idx_ff;
            vic_key_ff   <= rd_key;
         end
         if (!slot_ok && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_slot_ff  <= cmp_idx_ff;
         end
      end
   end

   // write-back commands
   always_comb begin
      rank_cmd.kind       = lkv_pkg::CMD_NONE;
      rank_cmd.slot       = target;
      rank_cmd.touch_rank = touch_rank_ff;
      rank_cmd.evict      = do_evict;
      store_wr.key_en     = 1'b0;
      store_wr.val_en     = 1'b0;
      store_wr.addr       = target;
      store_wr.key        = key_ff;
      store_wr.value      = wval_ff;
      if (advance) begin
         if (hit_ff) begin
            rank_cmd.kind   = lkv_pkg::CMD_TOUCH;
            store_wr.val_en = (op_ff == lkv_pkg::OP_PUT);
         end else if (op_ff == lkv_pkg::OP_PUT) begin
            rank_cmd.kind   = lkv_pkg::CMD_INSERT;
            store_wr.key_en = 1'b1;
            store_wr.val_en = 1'b1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff     <= hit_ff;
         rsp_evicted_ff <= do_evict;
         rsp_evk_ff     <= do_evict ? vic_key_ff : '0;
         if (op_ff == lkv_pkg::OP_PUT) begin
            rsp_rd_ff <= '0;
         end else begin
            rsp_rd_ff <= hit_ff ? hit_val_ff : lkv_pkg::MISS_VALUE;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.hit         = rsp_hit_ff;
   assign rsp_bus.read_value  = rsp_rd_ff;
   assign rsp_bus.evicted     = rsp_evicted_ff;
   assign rsp_bus.evicted_key = rsp_evk_ff;

   lkv_store u_store (
      .clock     (clock),
      .wr        (store_wr),
      .rd_addr   (cmp_idx_in),
      .rd_key_ff (rd_key),
      .rd_val_ff (rd_val)
   );

   lkv_recency u_recency (
      .clock    (clock),
      .reset    (reset),
      .clear    (csr_wr_en),
      .cmd      (rank_cmd),
      .rd_idx   (cmp_idx_ff),
      .rd_rank  (rd_rank),
      .valid_ff (valid),
      .count_ff (count)
   );

   // occupancy count tracks the valid bits
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      lkv_pkg::CNT_W'($countones(valid)) == count)
      else $error("occupancy count differs from valid bits");

   // occupancy never exceeds the effective capacity
   a_count_within_cap: assert property (@(posedge clock) disable iff (reset)
      lkv_pkg::CMP_W'(count) <= eff_cap)
      else $error("occupancy above capacity");

   // a response only appears out of the write-back step
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_UPDATE))
      else $error("response raised outside write-back");

   // after a put the target slot holds a valid entry
   a_put_leaves_valid: assert property (@(posedge clock) disable iff (reset)
      (advance && (op_ff == lkv_pkg::OP_PUT) && !csr_wr_en) |=> valid[$past(target)])
      else $error("put left target slot invalid");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the LRU key/value cache: directed, random and back-pressure tests.
`timescale 1ns / 1ps

// The cache takes one get or put per request transfer and returns exactly one
// response transfer per request. Expected responses are worked out by a
// behavioural LRU table kept in this module, queued in request order and
// compared field by field with every response transfer.
module testbench;

   // One response as the checker sees it.
   typedef struct packed {
      logic                       hit;
      logic [lkv_pkg::DATA_W-1:0] read_value;
      logic                       evicted;
      logic [lkv_pkg::DATA_W-1:0] evicted_key;
   } lookup_result_type;

   bit clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [lkv_pkg::CAP_W-1:0] csr_wr_data;

   lkv_req_if req_bus ();
   lkv_rsp_if rsp_bus ();

   lru_key_value_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow LRU table. Rank 0 is the most recent entry; the least recent
   // valid entry carries the largest rank.
   // ------------------------------------------------------------------
   logic [lkv_pkg::DATA_W-1:0] shadow_key   [lkv_pkg::MAX_ENTRIES];
   logic [lkv_pkg::DATA_W-1:0] shadow_value [lkv_pkg::MAX_ENTRIES];
   bit                         shadow_valid [lkv_pkg::MAX_ENTRIES];
   int unsigned                shadow_rank  [lkv_pkg::MAX_ENTRIES];
   int unsigned                shadow_count;
   logic [lkv_pkg::CAP_W-1:0]  shadow_capacity;

   lookup_result_type awaited_responses[$];
   int                fail_count = 0;

   // Sender and receiver pacing controls, shared with the test tasks.
   bit no_idle = 1'b0;
   int holdoff_cycles = 0;

   function automatic void empty_shadow();
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i]  = 0;
      end
      shadow_count = 0;
   endfunction

   // Make slot s the most recent; every more recent valid slot ages by one.
   function automatic void promote(int s);
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
         if (shadow_valid[i] && i != s && shadow_rank[i] < shadow_rank[s])
            shadow_rank[i]++;
      shadow_rank[s] = 0;
   endfunction

   function automatic lookup_result_type lru_predict(logic op,
                                                     logic [lkv_pkg::DATA_W-1:0] key,
                                                     logic [lkv_pkg::DATA_W-1:0] val);
      lookup_result_type res;
      int found;
      int victim;
      int unsigned worst;
      int unsigned limit;
      found  = -1;
      victim = -1;
      worst  = 0;
      res    = '0;
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
         if (found < 0 && shadow_valid[i] && shadow_key[i] == key)
            found = i;
      res.hit = (found >= 0);
      if (op == lkv_pkg::OP_GET) begin
         if (found >= 0) begin
            res.read_value = shadow_value[found];
            promote(found);
         end else begin
            res.read_value = lkv_pkg::MISS_VALUE;
         end
      end else if (found >= 0) begin
         shadow_value[found] = val;
         promote(found);
      end else begin
         // capacity 0 behaves as 1, anything past the table size as the table size
         limit = (shadow_capacity == 0) ? 1 : int'(shadow_capacity);
         if (limit > lkv_pkg::MAX_ENTRIES)
            limit = lkv_pkg::MAX_ENTRIES;
         if (shadow_count >= limit) begin
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
               if (shadow_valid[i] && (victim < 0 || shadow_rank[i] >= worst)) begin
                  worst  = shadow_rank[i];
                  victim = i;
               end
            if (victim >= 0) begin
               res.evicted         = 1'b1;
               res.evicted_key     = shadow_key[victim];
               shadow_valid[victim] = 1'b0;
               shadow_count--;
            end
         end
         for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
            if (victim < 0 && !shadow_valid[i])
               victim = i;
         if (victim >= 0) begin
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
               if (shadow_valid[i])
                  shadow_rank[i]++;
            shadow_key[victim]   = key;
            shadow_value[victim] = val;
            shadow_valid[victim] = 1'b1;
            shadow_rank[victim]  = 0;
            shadow_count++;
         end
      end
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return 0;
      else if (pick < 85)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------
   // Request side. Every task here is entered and left at a rising edge.
   // valid is left high after a transfer so a back-to-back item needs only
   // the one assignment in that step.
   // ------------------------------------------------------------------
   task automatic send_op(input logic op, input logic [lkv_pkg::DATA_W-1:0] key,
                          input logic [lkv_pkg::DATA_W-1:0] val);
      int gap;
      gap = no_idle ? 0 : gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.lookup_key  <= key;
      req_bus.write_value <= val;
      do @(posedge clock); while (!req_bus.ready);
      awaited_responses.push_back(lru_predict(op, key, val));
   endtask

   // Stop offering, let every response arrive, then allow the write-back to settle.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (awaited_responses.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Capacity write, only with the block idle; it empties the cache.
   task automatic set_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      shadow_capacity = cap;
      empty_shadow();
      csr_wr_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Response side: ready with random stalls, plus an optional long hold-off
   // counted down here.
   // ------------------------------------------------------------------
   initial begin : rsp_pacer
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            holdoff_cycles--;
         end else if (no_idle) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall_left = gap_len();
         end
      end
   end

   // Each response transfer is matched against the oldest prediction.
   always @(posedge clock) begin : check_responses
      lookup_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_responses.size() == 0) begin
            $error("response transfer with no request outstanding");
            fail_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_bus.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_bus.hit);
               fail_count++;
            end
            if (rsp_bus.read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_bus.read_value);
               fail_count++;
            end
            if (rsp_bus.evicted !== want.evicted) begin
               $error("evicted: expected %0d, got %0d", want.evicted, rsp_bus.evicted);
               fail_count++;
            end
            if (rsp_bus.evicted_key !== want.evicted_key) begin
               $error("evicted_key: expected %h, got %h", want.evicted_key,
                      rsp_bus.evicted_key);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Field extremes, miss/hit/update, eviction order, capacity corner values.
   task automatic test_directed();
      // empty cache after reset, capacity 16
      send_op(lkv_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_op(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_op(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_op(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_op(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      // a stored -1 must read back as a hit, not look like a miss
      send_op(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_op(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0005);
      send_op(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      // smallest capacity: every new key evicts the last one
      set_capacity(5'd1);
      send_op(lkv_pkg::OP_PUT, 32'h0000_00A1, 32'h1111_1111);
      send_op(lkv_pkg::OP_PUT, 32'h0000_00B2, 32'h2222_2222);
      send_op(lkv_pkg::OP_GET, 32'h0000_00A1, 32'h0000_0000);
      // zero behaves as one
      set_capacity(5'd0);
      send_op(lkv_pkg::OP_PUT, 32'h0000_00C3, 32'h3333_3333);
      send_op(lkv_pkg::OP_PUT, 32'h0000_00D4, 32'h4444_4444);
      send_op(lkv_pkg::OP_GET, 32'h0000_00D4, 32'h0000_0000);
      // a get refreshes recency, so the other entry is the victim
      set_capacity(5'd2);
      send_op(lkv_pkg::OP_PUT, 32'h0000_00A1, 32'h5555_5555);
      send_op(lkv_pkg::OP_PUT, 32'h0000_00B2, 32'h6666_6666);
      send_op(lkv_pkg::OP_GET, 32'h0000_00A1, 32'h0000_0000);
      send_op(lkv_pkg::OP_PUT, 32'h0000_00E5, 32'h7777_7777);
      send_op(lkv_pkg::OP_GET, 32'h0000_00B2, 32'h0000_0000);
      // rewriting the same capacity still empties the cache
      set_capacity(5'd2);
      send_op(lkv_pkg::OP_GET, 32'h0000_00A1, 32'h0000_0000);
   endtask

   // Random gets and puts over a small key pool per phase so hits, updates
   // and evictions are all frequent; a few stray keys add misses.
   task automatic test_random_phases();
      logic [lkv_pkg::CAP_W-1:0] caps[$];
      logic [lkv_pkg::DATA_W-1:0] key_pool[$];
      logic [lkv_pkg::DATA_W-1:0] key;
      int unsigned eff;
      int items;
      caps = '{5'd31, 5'd4, 5'd16, 5'd1, 5'd0, 5'd23, 5'd2, 5'd8};
      repeat (3) caps.push_back(lkv_pkg::CAP_W'($urandom_range(0, 31)));
      foreach (caps[p]) begin
         set_capacity(caps[p]);
         no_idle = (p % 3 == 2);
         eff = (caps[p] == 0) ? 1 :
               (caps[p] > lkv_pkg::MAX_ENTRIES ? lkv_pkg::MAX_ENTRIES : caps[p]);
         key_pool.delete();
         repeat (eff + $urandom_range(0, 3)) key_pool.push_back($urandom);
         items = (p < 8) ? 80 : 25;
         repeat (items) begin
            if ($urandom_range(0, 9) == 0)
               key = $urandom;
            else
               key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_op(logic'($urandom_range(0, 1)), key, $urandom);
         end
      end
      no_idle = 1'b0;
   endtask

   // Receiver holds off for a long stretch while items keep coming, so the
   // output register fills, the write-back waits and the request side stalls.
   task automatic test_backpressure();
      set_capacity(5'd3);
      holdoff_cycles = 250;
      no_idle = 1'b1;
      for (int i = 0; i < 8; i++)
         send_op(logic'(i % 2 == 0), 32'h0000_0010 + (i % 4), $urandom);
      no_idle = 1'b0;
   endtask

   initial begin : main
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.operation   <= lkv_pkg::OP_GET;
      req_bus.lookup_key  <= '0;
      req_bus.write_value <= '0;
      shadow_capacity = lkv_pkg::CAP_RESET;
      empty_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phases();
      test_backpressure();

      wait_drained();
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Generous ceiling: far beyond the slowest legal run of this stimulus.
   initial begin : watchdog
      #6_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
